/* hdl/bfr_pkg.sv */
// Shared constants, codes and handshake structs for the binary frame receiver.
// Used by bfr_arith and by the binary_frame_receiver_dispatch top level.
package bfr_pkg;

    localparam int MAX_FRAME   = 12;
    localparam int MIN_FRAME   = 4;
    localparam int CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int STORE_DEPTH = 9;
    localparam int SIDX_W      = $clog2(STORE_DEPTH);

    localparam logic [7:0] CAR_ADDR   = 8'd1;
    localparam logic [7:0] HEART_ADDR = 8'd0;
    localparam logic [7:0] CAR_LEN    = 8'd10;
    localparam logic [7:0] HEART_LEN  = 8'd4;

    localparam logic [2:0] ST_CAR_OK  = 3'd0;
    localparam logic [2:0] ST_HEART   = 3'd1;
    localparam logic [2:0] ST_SUM_ERR = 3'd2;
    localparam logic [2:0] ST_LEN_ERR = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_DUTY   = 2'd1;
    localparam logic [1:0] REG_PMIN   = 2'd2;
    localparam logic [1:0] REG_PMAX   = 2'd3;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic        start;
        arith_op_t   op;
        logic [23:0] a;
        logic [15:0] b;
    } arith_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] result;
    } arith_rsp_t;

endpackage

/* hdl/bfr_arith.sv */
// Shared iterative unit: shift-add multiply (a times low 8 bits of b, 8 steps)
// and restoring divide (24-bit a by 16-bit b, 24 steps). Depends on bfr_pkg.
module bfr_arith
    import bfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    arith_op_t   op_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] acc_reg;
    logic [31:0] sh_reg;
    logic [15:0] mb_reg;
    logic [15:0] rem_reg;

    logic [16:0] trial;
    logic        fits;
    logic        last;

    always_comb
    begin
        trial = {rem_reg, sh_reg[23]};
        fits  = trial >= {1'b0, mb_reg};
        last  = (op_reg == OP_MUL) ? (cnt_reg == 5'd7) : (cnt_reg == 5'd23);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            sh_reg   <= '0;
            mb_reg   <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                sh_reg   <= {8'd0, req.a};
                mb_reg   <= req.b;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (op_reg == OP_MUL)
                begin
                    if (mb_reg[0])
                        acc_reg <= acc_reg + sh_reg;
                    sh_reg <= {sh_reg[30:0], 1'b0};
                    mb_reg <= {1'b0, mb_reg[15:1]};
                end
                else
                begin
                    // shift in next dividend bit, subtract when the divisor fits
                    rem_reg <= fits ? 16'(trial - {1'b0, mb_reg}) : trial[15:0];
                    acc_reg <= {acc_reg[30:0], fits};
                    sh_reg  <= {sh_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

/* hdl/binary_frame_receiver_dispatch.sv */
// Binary frame receiver: header/length framing, additive checksum, car dispatch.
// Byte input channel (in_valid/in_ready/rx_byte), one result per completed frame
// on the output channel (out_valid/out_ready). A plain write port (cfg_we,
// cfg_index, cfg_data) sets header byte, duty full scale and servo limits.
// Bytes inside a frame are taken one per cycle. The byte that completes a frame
// starts post-processing: non-car frames go straight to the final state, and car
// frames run their multiplies and divides on the shared multiply/divide unit.
// During post-processing in_ready is low.
// The result lands in an output register; the block goes back to taking bytes
// while it waits to be taken. A second completed frame holds in the final state
// until the output register frees up, so a stalled receiver stalls the bytes.
// Reset returns to idle (hunting for the header), clears the output valid and
// restores register defaults (header 0x42, duty 1599, servo 500..2500 us).
// Depends on bfr_pkg and bfr_arith.
module binary_frame_receiver_dispatch
    import bfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [7:0]        frame_address,
    output logic [3:0]        frame_length,
    output logic signed [7:0] motor_percent,
    output logic [1:0]        motor_direction,
    output logic [15:0]       motor_duty,
    output logic [15:0]       servo_pulse,
    output logic [7:0]        servo_angle,
    output logic [7:0]        sum_computed,
    output logic [7:0]        sum_received
);

    typedef enum logic [3:0] {
        S_RX,
        S_EVAL,
        S_MUL100,
        S_MULDUTY,
        S_DIVDUTY,
        S_MULANG,
        S_DIVANG,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [7:0]  header_reg;
    logic [15:0] duty_fs_reg;
    logic [15:0] pmin_reg;
    logic [15:0] pmax_reg;

    logic             receiving_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       store_reg [STORE_DEPTH];

    logic [7:0]  len_hold_reg;
    logic [7:0]  sum_hold_reg;
    logic [7:0]  last_reg;
    logic [2:0]  stat_reg;
    logic        neg_reg;
    logic [6:0]  mag_reg;
    logic [15:0] duty_reg;
    logic [15:0] pulse_reg;
    logic [7:0]  angle_reg;

    logic        out_valid_reg;
    logic [2:0]  o_status_reg;
    logic [7:0]  o_addr_reg;
    logic [3:0]  o_len_reg;
    logic [7:0]  o_pct_reg;
    logic [1:0]  o_dir_reg;
    logic [15:0] o_duty_reg;
    logic [15:0] o_pulse_reg;
    logic [7:0]  o_angle_reg;
    logic [7:0]  o_sumc_reg;
    logic [7:0]  o_sumr_reg;

    arith_req_t arq_reg;
    arith_rsp_t ars;

    logic [CNT_W:0] cnt_inc;
    logic [7:0]     len_byte;
    logic           len_bad;
    logic           frame_end;
    logic [31:0]    spd_bits;
    logic [7:0]     spd_ex;
    logic           spd_nan;
    logic [15:0]    raw_pulse;
    logic [15:0]    pulse_lo;
    logic [15:0]    pulse_clamp;
    logic [2:0]     eval_stat;
    logic [6:0]     mag_scaled;

    // Round the mantissa product to 24 significant bits, nearest even, then
    // truncate by the exponent shift. The result is only used for exponents 111..126.
    function automatic logic [6:0] scale_mag(input logic [31:0] p, input logic [7:0] ex);
        logic [23:0] q;
        logic [6:0]  r;
        logic [6:0]  half;
        logic        up;
        logic [31:0] qr;
        logic [31:0] pr;
        logic [7:0]  s;
        if (p[30])
        begin
            q    = p[30:7];
            r    = p[6:0];
            half = 7'd64;
        end
        else
        begin
            q    = p[29:6];
            r    = {1'b0, p[5:0]};
            half = 7'd32;
        end
        up = (r > half) || ((r == half) && q[0]);
        qr = {8'd0, q} + {31'd0, up};
        pr = p[30] ? (qr << 7) : (qr << 6);
        s  = 8'd150 - ex;
        return pr[6 +: 26] == '0 ? 7'((pr >> s[5:0])) : 7'((pr >> s[5:0]));
    endfunction

    bfr_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arq_reg),
        .rsp   (ars)
    );

    always_comb
    begin
        cnt_inc     = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
        len_byte    = (count_reg == CNT_W'(2)) ? rx_byte : store_reg[2];
        len_bad     = (len_byte > 8'(MAX_FRAME)) || (len_byte < 8'(MIN_FRAME));
        frame_end   = 9'(cnt_inc) >= {1'b0, len_byte};
        spd_bits    = {store_reg[6], store_reg[5], store_reg[4], store_reg[3]};
        spd_ex      = spd_bits[30:23];
        spd_nan     = (spd_ex == 8'hFF) && (spd_bits[22:0] != '0);
        raw_pulse   = {store_reg[8], store_reg[7]};
        pulse_lo    = (raw_pulse < pmin_reg) ? pmin_reg : raw_pulse;
        pulse_clamp = (pulse_lo > pmax_reg) ? pmax_reg : pulse_lo;
        mag_scaled  = scale_mag(ars.result, spd_ex);
        if (sum_hold_reg != last_reg)
            eval_stat = ST_SUM_ERR;
        else if (store_reg[1] == CAR_ADDR)
            eval_stat = (len_hold_reg != CAR_LEN) ? ST_LEN_ERR : ST_CAR_OK;
        else if (store_reg[1] == HEART_ADDR)
            eval_stat = (len_hold_reg != HEART_LEN) ? ST_LEN_ERR : ST_HEART;
        else
            eval_stat = ST_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RX;
            header_reg    <= 8'h42;
            duty_fs_reg   <= 16'd1599;
            pmin_reg      <= 16'd500;
            pmax_reg      <= 16'd2500;
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            arq_reg       <= '0;
        end
        else
        begin
            arq_reg.start <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_HEADER: header_reg  <= cfg_data[7:0];
                    REG_DUTY:   duty_fs_reg <= cfg_data;
                    REG_PMIN:   pmin_reg    <= cfg_data;
                    REG_PMAX:   pmax_reg    <= cfg_data;
                    default:    ;
                endcase
            end

            unique case (state_reg)
                S_RX:
                begin
                    if (in_valid)
                    begin
                        if (!receiving_reg)
                        begin
                            if (rx_byte == header_reg)
                            begin
                                receiving_reg <= 1'b1;
                                store_reg[0]  <= rx_byte;
                                count_reg     <= CNT_W'(1);
                                sum_reg       <= rx_byte;
                            end
                        end
                        else if (count_reg >= CNT_W'(MAX_FRAME))
                        begin
                            receiving_reg <= 1'b0;
                            count_reg     <= '0;
                            sum_reg       <= '0;
                        end
                        else
                        begin
                            if (count_reg < CNT_W'(STORE_DEPTH))
                                store_reg[count_reg[SIDX_W-1:0]] <= rx_byte;
                            if (cnt_inc < (CNT_W+1)'(3))
                            begin
                                sum_reg   <= sum_reg + rx_byte;
                                count_reg <= cnt_inc[CNT_W-1:0];
                            end
                            else if (len_bad)
                            begin
                                receiving_reg <= 1'b0;
                                count_reg     <= '0;
                                sum_reg       <= '0;
                            end
                            else if (frame_end)
                            begin
                                len_hold_reg  <= len_byte;
                                sum_hold_reg  <= sum_reg;
                                last_reg      <= rx_byte;
                                receiving_reg <= 1'b0;
                                count_reg     <= '0;
                                sum_reg       <= '0;
                                state_reg     <= S_EVAL;
                            end
                            else
                            begin
                                sum_reg   <= sum_reg + rx_byte;
                                count_reg <= cnt_inc[CNT_W-1:0];
                            end
                        end
                    end
                end
                S_EVAL:
                begin
                    stat_reg  <= eval_stat;
                    neg_reg   <= spd_bits[31];
                    mag_reg   <= '0;
                    duty_reg  <= '0;
                    pulse_reg <= '0;
                    angle_reg <= '0;
                    if (eval_stat == ST_CAR_OK)
                    begin
                        pulse_reg   <= pulse_clamp;
                        arq_reg.op  <= OP_MUL;
                        arq_reg.a   <= {8'd0, duty_fs_reg};
                        arq_reg.start <= 1'b1;
                        if (spd_nan || spd_ex <= 8'd110)
                        begin
                            arq_reg.b <= '0;
                            state_reg <= S_MULDUTY;
                        end
                        else if (spd_ex >= 8'd127)
                        begin
                            mag_reg   <= 7'd100;
                            arq_reg.b <= 16'd100;
                            state_reg <= S_MULDUTY;
                        end
                        else
                        begin
                            arq_reg.a <= {1'b1, spd_bits[22:0]};
                            arq_reg.b <= 16'd100;
                            state_reg <= S_MUL100;
                        end
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_MUL100:
                begin
                    if (ars.done)
                    begin
                        mag_reg       <= mag_scaled;
                        arq_reg.op    <= OP_MUL;
                        arq_reg.a     <= {8'd0, duty_fs_reg};
                        arq_reg.b     <= {9'd0, mag_scaled};
                        arq_reg.start <= 1'b1;
                        state_reg     <= S_MULDUTY;
                    end
                end
                S_MULDUTY:
                begin
                    if (ars.done)
                    begin
                        arq_reg.op    <= OP_DIV;
                        arq_reg.a     <= ars.result[23:0];
                        arq_reg.b     <= 16'd100;
                        arq_reg.start <= 1'b1;
                        state_reg     <= S_DIVDUTY;
                    end
                end
                S_DIVDUTY:
                begin
                    if (ars.done)
                    begin
                        duty_reg <= ars.result[15:0];
                        if (pmax_reg > pmin_reg)
                        begin
                            arq_reg.op    <= OP_MUL;
                            arq_reg.a     <= {8'd0, 16'(pulse_reg - pmin_reg)};
                            arq_reg.b     <= 16'd180;
                            arq_reg.start <= 1'b1;
                            state_reg     <= S_MULANG;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_MULANG:
                begin
                    if (ars.done)
                    begin
                        arq_reg.op    <= OP_DIV;
                        arq_reg.a     <= ars.result[23:0];
                        arq_reg.b     <= 16'(pmax_reg - pmin_reg);
                        arq_reg.start <= 1'b1;
                        state_reg     <= S_DIVANG;
                    end
                end
                S_DIVANG:
                begin
                    if (ars.done)
                    begin
                        angle_reg <= ars.result[7:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        o_status_reg  <= stat_reg;
                        o_addr_reg    <= store_reg[1];
                        o_len_reg     <= len_hold_reg[3:0];
                        o_pct_reg     <= neg_reg ? 8'(-{1'b0, mag_reg}) : {1'b0, mag_reg};
                        o_dir_reg     <= (mag_reg == '0) ? DIR_STOP
                                         : (neg_reg ? DIR_REV : DIR_FWD);
                        o_duty_reg    <= duty_reg;
                        o_pulse_reg   <= pulse_reg;
                        o_angle_reg   <= angle_reg;
                        o_sumc_reg    <= sum_hold_reg;
                        o_sumr_reg    <= last_reg;
                        state_reg     <= S_RX;
                    end
                end
                default: state_reg <= S_RX;
            endcase
        end
    end

    assign in_ready        = (state_reg == S_RX);
    assign out_valid       = out_valid_reg;
    assign status          = o_status_reg;
    assign frame_address   = o_addr_reg;
    assign frame_length    = o_len_reg;
    assign motor_percent   = o_pct_reg;
    assign motor_direction = o_dir_reg;
    assign motor_duty      = o_duty_reg;
    assign servo_pulse     = o_pulse_reg;
    assign servo_angle     = o_angle_reg;
    assign sum_computed    = o_sumc_reg;
    assign sum_received    = o_sumr_reg;

`ifndef SYNTH
    a_unit_idle_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RX) |-> !ars.busy)
        else $error("arith unit busy while taking bytes");
    a_noncar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_CAR_OK) |-> (motor_duty == '0 && servo_angle == '0
            && motor_direction == DIR_STOP))
        else $error("car fields set on non-car result");
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_CAR_OK) |-> (servo_angle <= 8'd180))
        else $error("servo angle out of range");
`endif

endmodule
